[src/isfp_pkg.sv]
// Shared types, constants and helpers for the IMU serial frame parser.
// No dependencies; every other file of the block uses this package.
package isfp_pkg;

  // Frame geometry: one sync byte, one type byte, eight payload bytes, one checksum.
  localparam int unsigned WinLen  = 11;
  localparam int unsigned TailLen = WinLen - 1;

  localparam logic [3:0] FreshMax = 4'(WinLen);

  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [7:0] TypeFirst = 8'h51;
  localparam logic [7:0] TypeLast  = 8'h5A;

  localparam int unsigned QueueDepth = 2;

  // Frame kinds, the type byte minus the first type code.
  localparam logic [3:0] KindAccel   = 4'd0;
  localparam logic [3:0] KindGyro    = 4'd1;
  localparam logic [3:0] KindAngle   = 4'd2;
  localparam logic [3:0] KindMag     = 4'd3;
  localparam logic [3:0] KindPort    = 4'd4;
  localparam logic [3:0] KindQuat    = 4'd8;
  localparam logic [3:0] KindLastVal = 4'd9;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
  } frame_t;

  // Sticky flag that a frame kind raises; kinds without a flag give zero.
  function automatic logic [5:0] seen_flag(input logic [3:0] kind);
    logic [5:0] flag;
    flag = 6'h00;
    case (kind)
      KindAccel: flag = 6'h01;
      KindGyro:  flag = 6'h02;
      KindMag:   flag = 6'h04;
      KindAngle: flag = 6'h08;
      KindQuat:  flag = 6'h10;
      KindPort:  flag = 6'h20;
      default:   flag = 6'h00;
    endcase
    return flag;
  endfunction

endpackage

[src/isfp_front.sv]
// Front end of the frame parser: byte window, running checksum and frame detection.
// Depends on isfp_pkg.
module isfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_in_i,
  output logic                hit_o,
  output isfp_pkg::frame_t    frame_o
);

  // The tail holds window bytes one to ten; the oldest byte is never needed again.
  logic [7:0] tail_q [isfp_pkg::TailLen];
  logic [7:0] sum_q, sum_d;
  logic [3:0] fresh_q, fresh_d, fresh_sat;
  logic       type_ok;

  assign fresh_sat = (fresh_q == isfp_pkg::FreshMax) ? fresh_q : fresh_q + 4'd1;
  assign type_ok   = (tail_q[1] >= isfp_pkg::TypeFirst) && (tail_q[1] <= isfp_pkg::TypeLast);

  // The sum of the new window's first ten bytes is the sum of the old tail.
  assign hit_o = accept_i && (fresh_sat == isfp_pkg::FreshMax)
                 && (tail_q[0] == isfp_pkg::SyncByte) && type_ok
                 && (sum_q == byte_in_i);

  assign sum_d   = sum_q - tail_q[0] + byte_in_i;
  assign fresh_d = hit_o ? 4'd0 : fresh_sat;

  always_comb begin
    frame_o.kind   = 4'(tail_q[1] - isfp_pkg::TypeFirst);
    frame_o.word_a = {tail_q[3], tail_q[2]};
    frame_o.word_b = {tail_q[5], tail_q[4]};
    frame_o.word_c = {tail_q[7], tail_q[6]};
    frame_o.word_d = {tail_q[9], tail_q[8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < isfp_pkg::TailLen; i++) begin
        tail_q[i] <= 8'h00;
      end
      sum_q   <= 8'h00;
      fresh_q <= 4'd0;
    end else if (accept_i) begin
      for (int i = 0; i < isfp_pkg::TailLen - 1; i++) begin
        tail_q[i] <= tail_q[i+1];
      end
      tail_q[isfp_pkg::TailLen-1] <= byte_in_i;
      sum_q   <= sum_d;
      fresh_q <= fresh_d;
    end
  end

`ifndef SYNTH
  // The fresh count saturates at the window length.
  a_fresh_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= isfp_pkg::FreshMax)
    else $error("fresh count beyond window length");

  // A detected frame consumes the whole window.
  a_hit_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |=> (fresh_q == 4'd0))
    else $error("window not consumed after frame");
`endif

endmodule

[src/isfp_queue.sv]
// Short first-in first-out queue of detected frames between front and back end.
// Depends on isfp_pkg for the frame type.
module isfp_queue #(
  parameter int unsigned Depth = isfp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  isfp_pkg::frame_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output isfp_pkg::frame_t data_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  isfp_pkg::frame_t mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  // Occupancy never exceeds the queue depth.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue overflow");
`endif

endmodule

[src/isfp_back.sv]
// Back end of the frame parser: sticky seen flags and the output register.
// Depends on isfp_pkg.
module isfp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  isfp_pkg::frame_t q_data_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [3:0]       frame_kind_o,
  output logic [15:0]      word_a_o,
  output logic [15:0]      word_b_o,
  output logic [15:0]      word_c_o,
  output logic [15:0]      word_d_o,
  output logic [5:0]       seen_mask_o
);

  logic             out_valid_q;
  isfp_pkg::frame_t out_q;
  logic [5:0]       seen_q, seen_d;
  logic [5:0]       mask_q;

  // Load a new frame when the output word is free or leaves this cycle.
  assign q_pop_o = q_valid_i && (!out_valid_q || pop);
  assign seen_d  = seen_q | isfp_pkg::seen_flag(q_data_i.kind);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seen_q      <= 6'h00;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        seen_q      <= seen_d;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q  <= q_data_i;
      mask_q <= seen_d;
    end
  end

  assign empty        = !out_valid_q;
  assign frame_kind_o = out_q.kind;
  assign word_a_o     = out_q.word_a;
  assign word_b_o     = out_q.word_b;
  assign word_c_o     = out_q.word_c;
  assign word_d_o     = out_q.word_d;
  assign seen_mask_o  = mask_q;

`ifndef SYNTH
  // Seen flags are sticky: no flag ever clears outside reset.
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(seen_q) & ~seen_q) == 6'h00))
    else $error("seen flag cleared");

  // Only frames with a type in range reach the output.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (frame_kind_o <= isfp_pkg::KindLastVal))
    else $error("frame kind out of range");
`endif

endmodule

[src/imu_serial_frame_parser.sv]
// A byte that completes a valid frame is pushed into the frame queue as it is accepted;
// the frame then enters the output register, and empty falls, once it is free.
// Throughput: one byte per cycle; full rises only when the frame queue backs up because
// results are not popped; the back end takes one queued frame per cycle as pops allow.
// Reset (rst_ni low, asynchronous) clears the byte window, checksum, fresh count, seen
// flags, queue pointers and output valid; no frame is found until eleven bytes arrive.
module imu_serial_frame_parser #(
  parameter int unsigned QueueDepth = isfp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  frame_kind_o,
  output logic [15:0] word_a_o,
  output logic [15:0] word_b_o,
  output logic [15:0] word_c_o,
  output logic [15:0] word_d_o,
  output logic [5:0]  seen_mask_o
);

  // The front end shifts every accepted word into the window and checks it in the
  // same cycle, using a running sum that drops the oldest byte and adds the new one.
  // A detected frame goes into a short queue; the back end drains that queue into
  // the output register and folds the frame kind into the sticky seen flags.
  logic             accept;
  logic             hit;
  isfp_pkg::frame_t front_frame;
  logic             q_valid;
  logic             q_pop;
  isfp_pkg::frame_t q_frame;

  // A word is taken whenever the queue has room, so the front never waits on the back
  // end unless the queue is full.
  assign accept = push && !full;

  isfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_in_i (byte_in_i),
    .hit_o     (hit),
    .frame_o   (front_frame)
  );

  isfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (hit),
    .data_i  (front_frame),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_frame)
  );

  isfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_frame),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .frame_kind_o (frame_kind_o),
    .word_a_o     (word_a_o),
    .word_b_o     (word_b_o),
    .word_c_o     (word_c_o),
    .word_d_o     (word_d_o),
    .seen_mask_o  (seen_mask_o)
  );

endmodule

[tb/isfp_frame_checker.sv]
// Checker for the IMU serial frame parser: follows the accepted byte stream, predicts
// each frame the parser must report and compares every popped result word.
// Depends on isfp_pkg for the frame geometry, type codes and the frame_t record.
module isfp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  byte_in_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  frame_kind_o,
  input  logic [15:0] word_a_o,
  input  logic [15:0] word_b_o,
  input  logic [15:0] word_c_o,
  input  logic [15:0] word_d_o,
  input  logic [5:0]  seen_mask_o,
  output int          errors_o,
  output int          frames_due_o
);
  import isfp_pkg::*;

  // Type bytes that raise a sticky flag.
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeGyro  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [7:0] TypeMag   = 8'h54;
  localparam logic [7:0] TypePort  = 8'h55;
  localparam logic [7:0] TypeQuat  = 8'h59;

  typedef struct packed {
    frame_t     frame;
    logic [5:0] seen;
  } frame_due_t;

  logic [7:0]  window [WinLen];
  logic [3:0]  fresh;
  logic [5:0]  seen;
  frame_due_t  frames_due [$];
  int          fail_count = 0;
  int          due_count = 0;

  assign errors_o     = fail_count;
  assign frames_due_o = due_count;

  function automatic logic [5:0] flag_of(input logic [7:0] tbyte);
    case (tbyte)
      TypeAccel: return 6'h01;
      TypeGyro:  return 6'h02;
      TypeMag:   return 6'h04;
      TypeAngle: return 6'h08;
      TypeQuat:  return 6'h10;
      TypePort:  return 6'h20;
      default:   return 6'h00;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] sum;
    frame_due_t next_due;
    frame_due_t head;
    if (!rst_ni) begin
      for (int i = 0; i < WinLen; i++) window[i] = 8'h00;
      fresh = 4'd0;
      seen  = 6'h00;
      frames_due.delete();
      due_count = 0;
    end else begin
      if (pop && !empty) begin
        if (frames_due.size() == 0) begin
          $display("%0t: result word with no frame pending, kind %h words %h %h %h %h seen %h",
                   $time, frame_kind_o, word_a_o, word_b_o, word_c_o, word_d_o, seen_mask_o);
          fail_count++;
        end else begin
          head = frames_due.pop_front();
          check_field("frame_kind", 16'(head.frame.kind), 16'(frame_kind_o));
          check_field("word_a", head.frame.word_a, word_a_o);
          check_field("word_b", head.frame.word_b, word_b_o);
          check_field("word_c", head.frame.word_c, word_c_o);
          check_field("word_d", head.frame.word_d, word_d_o);
          check_field("seen_mask", 16'(head.seen), 16'(seen_mask_o));
        end
      end
      if (push && !full) begin
        for (int i = 0; i < TailLen; i++) window[i] = window[i + 1];
        window[TailLen] = byte_in_i;
        if (fresh < FreshMax) fresh++;
        sum = 8'h00;
        for (int i = 0; i < TailLen; i++) sum += window[i];
        if (fresh == FreshMax && window[0] == SyncByte && window[1] >= TypeFirst &&
            window[1] <= TypeLast && sum == window[TailLen]) begin
          seen  = seen | flag_of(window[1]);
          fresh = 4'd0;
          next_due.frame.kind   = 4'(window[1] - TypeFirst);
          next_due.frame.word_a = {window[3], window[2]};
          next_due.frame.word_b = {window[5], window[4]};
          next_due.frame.word_c = {window[7], window[6]};
          next_due.frame.word_d = {window[9], window[8]};
          next_due.seen         = seen;
          frames_due.push_back(next_due);
        end
      end
      due_count = frames_due.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the IMU serial frame parser testbench: clock, reset, byte stimulus and the
// result-side pop pattern. Depends on isfp_pkg, imu_serial_frame_parser and isfp_frame_checker.
module testbench;
  import isfp_pkg::*;

  // A type byte that equals the sync byte; it lets a frame hide a second sync in its header.
  localparam logic [7:0] TypePort = 8'h55;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic        pop     = 1'b0;
  logic [7:0]  byte_in = 8'h00;
  logic        full;
  logic        empty;
  logic [3:0]  frame_kind;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  logic [5:0]  seen_mask;
  int          errors;
  int          frames_due;

  // Sender state: words left in the current burst and the running byte count.
  int          burst_left = 0;
  int          bytes_sent = 0;

  imu_serial_frame_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .byte_in_i    (byte_in),
    .empty        (empty),
    .pop          (pop),
    .frame_kind_o (frame_kind),
    .word_a_o     (word_a),
    .word_b_o     (word_b),
    .word_c_o     (word_c),
    .word_d_o     (word_d),
    .seen_mask_o  (seen_mask)
  );

  // The checker sees exactly what the parser sees at each rising edge, so it needs no
  // knowledge of the stimulus; it only hands back a failure count and the backlog.
  isfp_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .byte_in_i    (byte_in),
    .empty        (empty),
    .pop          (pop),
    .frame_kind_o (frame_kind),
    .word_a_o     (word_a),
    .word_b_o     (word_b),
    .word_c_o     (word_c),
    .word_d_o     (word_d),
    .seen_mask_o  (seen_mask),
    .errors_o     (errors),
    .frames_due_o (frames_due)
  );

  always #1 clk_i = ~clk_i;

  // Offers one input word and returns once it has been taken. Inputs change only at the
  // falling edge; acceptance is decided from full as it stands at the rising edge. When a
  // burst runs out, push drops for a random gap (sometimes none) before the next burst.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    push    <= 1'b1;
    byte_in <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // Payload byte with a bias toward the sync byte and toward valid type codes, so that
  // false sync candidates show up inside frames and sliding windows get tried.
  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return SyncByte;
    if (pick == 1) return TypeFirst + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] random_body();
    logic [63:0] body;
    for (int i = 0; i < 8; i++) body[8*i +: 8] = payload_byte();
    return body;
  endfunction

  // Sends sync, type, eight payload bytes and the checksum. When spoil is set the checksum
  // is flipped by a nonzero pattern so the frame must be dropped.
  task automatic send_frame(input logic [7:0] tbyte, input logic [63:0] body, input bit spoil,
                            output logic [7:0] csum);
    csum = SyncByte + tbyte;
    for (int i = 0; i < 8; i++) csum += body[8*i +: 8];
    if (spoil) csum ^= 8'($urandom_range(1, 255));
    push_byte(SyncByte);
    push_byte(tbyte);
    for (int i = 0; i < 8; i++) push_byte(body[8*i +: 8]);
    push_byte(csum);
  endtask

  initial begin
    logic [7:0]  csum;
    logic [7:0]  bad_type;
    logic [63:0] body;
    int          pick;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // A frame that begins with the very first byte after reset, at the lowest type code
    // with an all-zero payload.
    send_frame(TypeFirst, 64'h0, 1'b0, csum);

    // A frame whose type byte is itself a sync byte and whose first payload byte is the
    // highest type code, with the rest of the payload at its maximum. One more byte then
    // completes a window shifted by one that checks out but still overlaps the frame just
    // taken, so no result may come from it.
    body = {{7{8'hFF}}, TypeLast};
    send_frame(TypePort, body, 1'b0, csum);
    push_byte(8'(2 * csum - SyncByte));

    // Random part: mostly well-formed frames of every type with random payloads; the rest
    // are frames with a wrong checksum or an out-of-range type, and loose noise bytes.
    while (bytes_sent < 750) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(TypeFirst + 8'($urandom_range(0, 9)), random_body(), 1'b0, csum);
      end else if (pick < 80) begin
        send_frame(TypeFirst + 8'($urandom_range(0, 9)), random_body(), 1'b1, csum);
      end else if (pick < 88) begin
        do bad_type = 8'($urandom_range(0, 255));
        while (bad_type >= TypeFirst && bad_type <= TypeLast);
        send_frame(bad_type, random_body(), 1'b0, csum);
      end else begin
        repeat ($urandom_range(1, 5))
          push_byte(($urandom_range(0, 3) == 0) ? SyncByte : 8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk_i);
    push <= 1'b0;

    // Let the checker account for the last accepted word, then drain the result queue and
    // give the parser a few more cycles in case it emits something it should not.
    @(posedge clk_i);
    while (frames_due != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("imu_serial_frame_parser verification clean");
    end else begin
      $display("imu_serial_frame_parser verification failed");
    end
    $finish;
  end

  // Receiver: it redraws its stall rate periodically, from never stalling to popping
  // only now and then. Once, for a long stretch, it stops popping altogether while the
  // sender keeps going, so the frame queue fills and full has to hold the input off.
  initial begin
    int cyc;
    int stall_odds;
    cyc = 0;
    stall_odds = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_odds = 0;
          1: stall_odds = 25;
          2: stall_odds = 50;
          default: stall_odds = 80;
        endcase
      end
      if (cyc >= 300 && cyc < 560) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_odds);
      end
    end
  end

  // Watchdog: far beyond any correct run, even with every gap and stall at its longest.
  initial begin
    #400000;
    $display("imu_serial_frame_parser verification failed");
    $finish;
  end

endmodule
